// ===== sv/okel_pkg.sv =====
// ----------------------------------------------------------------------------
// okel_pkg: shared types and constants for the ordered keyed entry list
// Holds the sizing constants, action and status codes and the entry layout.
// ----------------------------------------------------------------------------
package okel_pkg;

  localparam int CAPACITY    = 64;
  localparam int HANDLE_BITS = 32;

  // Fixed field widths of the request and result ports
  localparam int ACTION_W = 3;
  localparam int KEY_W    = 64;
  localparam int KIND_W   = 4;
  localparam int HANDLE_W = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int OCNT_W   = 7;

  // Derived storage widths
  localparam int HSTORE_W = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_READ   = 3'd1,
    ACT_FIND   = 3'd2,
    ACT_ERASE  = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_RANGE     = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [KIND_W-1:0]   kind;
    logic [HSTORE_W-1:0] handle;
  } entry_t;

endpackage

// ===== sv/ordered_keyed_entry_list.sv =====
// ----------------------------------------------------------------------------
// ordered_keyed_entry_list: insertion-ordered list of keyed entries
// Append, read by position, find newest by key, erase all by key, clear.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a request by raising start with the in_* fields while busy is low;
//   the request is taken at that clock edge and busy rises on the next cycle.
//   Exactly one result follows per request: out_valid is high for a single
//   cycle with out_status, entry data and the two counts. The receiver
//   cannot stall, so the result must be captured in that cycle.
//   Every request is decoded in the exec state. Append, clear, unused
//   codes and out-of-range reads finish there; an in-range read is then
//   completed in the check state. Find fetches and checks entries from the
//   newest down and stops at the first hit or after the oldest entry; erase
//   fetches and checks every held entry. Walks are set by the single read
//   port of the entry memory and the one 64-bit key comparator: every entry
//   is fetched in the fetch state and then checked in the check state.
//   A new request may be issued in the cycle out_valid is high.
//   Reset (rst_n low, synchronous) empties the list and drops any request
//   in progress; entry memory contents are not cleared.
// ----------------------------------------------------------------------------
module ordered_keyed_entry_list (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [okel_pkg::ACTION_W-1:0]     in_action,
  input  logic [okel_pkg::KEY_W-1:0]        in_key_oid,
  input  logic [okel_pkg::KIND_W-1:0]       in_access_kind,
  input  logic [okel_pkg::HANDLE_W-1:0]     in_entry_handle,
  input  logic [okel_pkg::POS_W-1:0]        in_position,
  output logic                              out_valid,
  output logic [okel_pkg::STATUS_W-1:0]     out_status,
  output logic [okel_pkg::KEY_W-1:0]        out_oid,
  output logic [okel_pkg::KIND_W-1:0]       out_kind,
  output logic [okel_pkg::HANDLE_W-1:0]     out_handle,
  output logic [okel_pkg::OCNT_W-1:0]       out_stored_count,
  output logic [okel_pkg::OCNT_W-1:0]       out_removed_count
);

  localparam int ADDR_W   = okel_pkg::ADDR_W;
  localparam int CNT_W    = okel_pkg::CNT_W;
  localparam int CMP_W    = okel_pkg::CMP_W;
  localparam int HSTORE_W = okel_pkg::HSTORE_W;

  // Sequencer: decode the request, then alternate fetch and check per entry
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_FETCH = 4'b0100,
    ST_CHECK = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Latched request
  okel_pkg::action_t               act_r;
  logic [okel_pkg::KEY_W-1:0]      key_r;
  logic [okel_pkg::KIND_W-1:0]     kind_r;
  logic [HSTORE_W-1:0]             handle_r;
  logic [okel_pkg::POS_W-1:0]      pos_r;

  // List bookkeeping
  logic [CNT_W-1:0] cnt_r, cnt_nxt;       // entries held
  logic [CNT_W-1:0] idx_r, idx_nxt;       // scan pointer
  logic [CNT_W-1:0] wptr_r, wptr_nxt;     // compaction write pointer
  logic [CNT_W-1:0] rem_r, rem_nxt;       // entries removed so far

  // Result registers
  logic                              out_valid_r, out_valid_nxt;
  okel_pkg::status_t                 out_status_r, out_status_nxt;
  okel_pkg::entry_t                  out_entry_r, out_entry_nxt;
  logic [okel_pkg::OCNT_W-1:0]       out_scnt_r, out_scnt_nxt;
  logic [okel_pkg::OCNT_W-1:0]       out_rcnt_r, out_rcnt_nxt;

  // Entry memory: one write port, one registered read port
  okel_pkg::entry_t  mem [okel_pkg::CAPACITY];
  okel_pkg::entry_t  rd_data_r;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  okel_pkg::entry_t  wr_data;

  logic             accept;
  logic             key_hit;
  logic [CNT_W-1:0] idx_dec;

  assign accept  = start && (state_r == ST_IDLE);
  assign busy    = (state_r != ST_IDLE);
  // Shared key comparator, used by both find and erase
  assign key_hit = (rd_data_r.key == key_r);
  assign idx_dec = idx_r - 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Hold the request fields for the duration of the operation
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= okel_pkg::action_t'(in_action);
      key_r    <= in_key_oid;
      kind_r   <= in_access_kind;
      handle_r <= in_entry_handle[HSTORE_W-1:0];
      pos_r    <= in_position;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    wptr_nxt       = wptr_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = okel_pkg::STS_OK;
    out_entry_nxt  = '0;
    out_scnt_nxt   = okel_pkg::OCNT_W'(cnt_r);
    out_rcnt_nxt   = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = rd_data_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (act_r)
          okel_pkg::ACT_APPEND: begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
            if (cnt_r >= CNT_W'(okel_pkg::CAPACITY)) begin
              out_status_nxt = okel_pkg::STS_FULL;
            end else begin
              wr_en        = 1'b1;
              wr_addr      = cnt_r[ADDR_W-1:0];
              wr_data      = '{key: key_r, kind: kind_r, handle: handle_r};
              cnt_nxt      = cnt_r + 1'b1;
              out_scnt_nxt = okel_pkg::OCNT_W'(cnt_r + 1'b1);
            end
          end
          okel_pkg::ACT_READ: begin
            if (CMP_W'(pos_r) >= CMP_W'(cnt_r)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = okel_pkg::STS_RANGE;
              state_nxt      = ST_IDLE;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = ADDR_W'(pos_r);
              state_nxt = ST_CHECK;
            end
          end
          okel_pkg::ACT_FIND: begin
            // Walk from the newest entry down
            idx_nxt   = cnt_r;
            state_nxt = ST_FETCH;
          end
          okel_pkg::ACT_ERASE: begin
            idx_nxt   = '0;
            wptr_nxt  = '0;
            rem_nxt   = '0;
            state_nxt = ST_FETCH;
          end
          okel_pkg::ACT_CLEAR: begin
            out_valid_nxt = 1'b1;
            out_scnt_nxt  = '0;
            out_rcnt_nxt  = okel_pkg::OCNT_W'(cnt_r);
            cnt_nxt       = '0;
            state_nxt     = ST_IDLE;
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        endcase
      end

      ST_FETCH: begin
        if (act_r == okel_pkg::ACT_FIND) begin
          if (idx_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = okel_pkg::STS_NOT_FOUND;
            state_nxt      = ST_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = idx_dec[ADDR_W-1:0];
            state_nxt = ST_CHECK;
          end
        end else begin
          // Erase: finish once every held entry has been checked
          if (idx_r == cnt_r) begin
            out_valid_nxt = 1'b1;
            cnt_nxt       = wptr_r;
            out_scnt_nxt  = okel_pkg::OCNT_W'(wptr_r);
            out_rcnt_nxt  = okel_pkg::OCNT_W'(rem_r);
            if (rem_r == '0) begin
              out_status_nxt = okel_pkg::STS_NOT_FOUND;
            end
            state_nxt = ST_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = idx_r[ADDR_W-1:0];
            state_nxt = ST_CHECK;
          end
        end
      end

      ST_CHECK: begin
        case (act_r)
          okel_pkg::ACT_READ: begin
            out_valid_nxt = 1'b1;
            out_entry_nxt = rd_data_r;
            state_nxt     = ST_IDLE;
          end
          okel_pkg::ACT_FIND: begin
            if (key_hit) begin
              out_valid_nxt = 1'b1;
              out_entry_nxt = rd_data_r;
              state_nxt     = ST_IDLE;
            end else begin
              idx_nxt   = idx_dec;
              state_nxt = ST_FETCH;
            end
          end
          default: begin
            // Erase: drop matching entries, shift survivors down over the gap
            if (key_hit) begin
              rem_nxt = rem_r + 1'b1;
            end else begin
              wr_en    = 1'b1;
              wr_addr  = wptr_r[ADDR_W-1:0];
              wptr_nxt = wptr_r + 1'b1;
            end
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_FETCH;
          end
        endcase
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      wptr_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      wptr_r      <= wptr_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_scnt_r   <= out_scnt_nxt;
    out_rcnt_r   <= out_rcnt_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_oid           = out_entry_r.key;
  assign out_kind          = out_entry_r.kind;
  assign out_handle        = okel_pkg::HANDLE_W'(out_entry_r.handle);
  assign out_stored_count  = out_scnt_r;
  assign out_removed_count = out_rcnt_r;

endmodule

// ===== verif/ordered_keyed_entry_list_tb.sv =====
// ----------------------------------------------------------------------------
// ordered_keyed_entry_list_tb: self-checking bench for the ordered entry list
// Drives append, read, find, erase, clear and unused codes through the
// start/busy port. A shadow copy of the list predicts every result, and each
// result strobe is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ordered_keyed_entry_list_tb;
  import okel_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 9;
  localparam int TIMEOUT_CYCLES = 700000;
  // Longest request (erase of a full list) plus margin, used for the tail
  localparam int SETTLE_CYCLES  = 150;
  localparam int POOL_SIZE      = 8;
  localparam int RANDOM_ITEMS   = 800;
  localparam int DRAIN_EVERY    = 150;

  // Highest code the action field can carry; codes above clear are unused
  localparam logic [ACTION_W-1:0] ACT_CODE_MAX = '1;

  // One expected result of a request
  typedef struct {
    status_t              status;
    logic [KEY_W-1:0]     oid;
    logic [KIND_W-1:0]    kind;
    logic [HANDLE_W-1:0]  handle;
    logic [OCNT_W-1:0]    stored;
    logic [OCNT_W-1:0]    removed;
  } list_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [ACTION_W-1:0]  in_action = '0;
  logic [KEY_W-1:0]     in_key_oid = '0;
  logic [KIND_W-1:0]    in_access_kind = '0;
  logic [HANDLE_W-1:0]  in_entry_handle = '0;
  logic [POS_W-1:0]     in_position = '0;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [KEY_W-1:0]     out_oid;
  logic [KIND_W-1:0]    out_kind;
  logic [HANDLE_W-1:0]  out_handle;
  logic [OCNT_W-1:0]    out_stored_count;
  logic [OCNT_W-1:0]    out_removed_count;

  // Shadow copy of the list, oldest entry first
  entry_t               shadow_entries[$];
  // Results predicted but not yet seen on the result port
  list_result_t         pending_results[$];
  logic [KEY_W-1:0]     key_pool[POOL_SIZE];
  int                   mismatch_count = 0;
  // Requests left in the current sender burst
  int                   burst_left = 0;

  ordered_keyed_entry_list dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_key_oid        (in_key_oid),
    .in_access_kind    (in_access_kind),
    .in_entry_handle   (in_entry_handle),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_oid           (out_oid),
    .out_kind          (out_kind),
    .out_handle        (out_handle),
    .out_stored_count  (out_stored_count),
    .out_removed_count (out_removed_count)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Apply one accepted request to the shadow list and queue its result.
  // Data fields stay zero unless a read or find returns an entry; the
  // removed count is only set by erase and clear.
  function automatic void predict_list_result(
    input logic [ACTION_W-1:0] act,
    input logic [KEY_W-1:0]    key,
    input logic [KIND_W-1:0]   kind,
    input logic [HANDLE_W-1:0] handle,
    input logic [POS_W-1:0]    pos
  );
    list_result_t r;
    entry_t       e;
    entry_t       kept[$];
    int           removed;
    r.status = STS_OK;
    r.oid    = '0;
    r.kind   = '0;
    r.handle = '0;
    removed  = 0;
    case (act)
      ACT_APPEND: begin
        if (shadow_entries.size() >= CAPACITY) begin
          r.status = STS_FULL;
        end else begin
          e.key    = key;
          e.kind   = kind;
          e.handle = handle[HSTORE_W-1:0];
          shadow_entries.push_back(e);
        end
      end
      ACT_READ: begin
        if (pos >= shadow_entries.size()) begin
          r.status = STS_RANGE;
        end else begin
          e        = shadow_entries[pos];
          r.oid    = e.key;
          r.kind   = e.kind;
          r.handle = HANDLE_W'(e.handle);
        end
      end
      ACT_FIND: begin
        // Walk from the newest entry down; the first match wins
        r.status = STS_NOT_FOUND;
        for (int i = shadow_entries.size() - 1; i >= 0; i--) begin
          if (shadow_entries[i].key == key) begin
            r.status = STS_OK;
            r.oid    = shadow_entries[i].key;
            r.kind   = shadow_entries[i].kind;
            r.handle = HANDLE_W'(shadow_entries[i].handle);
            break;
          end
        end
      end
      ACT_ERASE: begin
        // Keep every non-matching entry in its original order
        foreach (shadow_entries[i]) begin
          if (shadow_entries[i].key == key) removed++;
          else kept.push_back(shadow_entries[i]);
        end
        shadow_entries = kept;
        if (removed == 0) r.status = STS_NOT_FOUND;
      end
      ACT_CLEAR: begin
        removed = shadow_entries.size();
        shadow_entries.delete();
      end
      default: begin
      end
    endcase
    r.stored  = OCNT_W'(shadow_entries.size());
    r.removed = OCNT_W'(removed);
    pending_results.push_back(r);
  endfunction

  // Issue one request and hold it until the block takes it. Open a gap of
  // random length whenever the current burst runs out; a quarter of the
  // bursts follow the previous one back to back.
  task automatic send_request(
    input logic [ACTION_W-1:0] act,
    input logic [KEY_W-1:0]    key,
    input logic [KIND_W-1:0]   kind,
    input logic [HANDLE_W-1:0] handle,
    input logic [POS_W-1:0]    pos
  );
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start           <= 1'b1;
    in_action       <= act;
    in_key_oid      <= key;
    in_access_kind  <= kind;
    in_entry_handle <= handle;
    in_position     <= pos;
    // The request is taken at the first edge that sees busy low
    do @(posedge clk); while (busy);
    predict_list_result(act, key, kind, handle, pos);
  endtask

  // Drop start and hold off until every predicted result has come back
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic refresh_key_pool();
    foreach (key_pool[i]) key_pool[i] = {$urandom(), $urandom()};
    // One key differs from another in a single bit, so a partial key
    // compare shows up as a false hit
    key_pool[POOL_SIZE-1] = key_pool[0] ^ (64'd1 << $urandom_range(0, KEY_W - 1));
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 3) == 0) return {$urandom(), $urandom()};
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Check every result strobe against the oldest prediction
  task automatic check_field(input string label, input logic [KEY_W-1:0] want,
                             input logic [KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: status %0d, stored %0d", $time,
                 out_status, out_stored_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", KEY_W'(want.status), KEY_W'(out_status));
        check_field("oid", want.oid, out_oid);
        check_field("kind", KEY_W'(want.kind), KEY_W'(out_kind));
        check_field("handle", KEY_W'(want.handle), KEY_W'(out_handle));
        check_field("stored_count", KEY_W'(want.stored), KEY_W'(out_stored_count));
        check_field("removed_count", KEY_W'(want.removed), KEY_W'(out_removed_count));
      end
    end
  end

  // Every action on small lists: empty-list failures, key extremes, the
  // range edge of read, newest-wins find, a one-bit key near miss, erase
  // with compaction, the unused codes and a final clear.
  task automatic test_basic_actions();
    logic [KEY_W-1:0] dup_key;
    dup_key = {$urandom(), $urandom()};
    send_request(ACT_CLEAR, '0, '0, '0, '0);
    send_request(ACT_READ, '0, '0, '0, '0);
    send_request(ACT_FIND, dup_key, '0, '0, '0);
    send_request(ACT_ERASE, dup_key, '0, '0, '0);
    send_request(ACT_APPEND, '0, '0, '0, '1);
    send_request(ACT_APPEND, '1, '1, '1, '0);
    send_request(ACT_APPEND, dup_key, 4'h5, $urandom(), '0);
    send_request(ACT_APPEND, dup_key ^ {1'b1, {(KEY_W-1){1'b0}}}, 4'ha, $urandom(), '0);
    send_request(ACT_APPEND, dup_key, 4'h3, $urandom(), '0);
    send_request(ACT_READ, '1, '1, '1, 6'd0);
    send_request(ACT_READ, '0, '0, '0, 6'd4);
    send_request(ACT_READ, '0, '0, '0, 6'd5);
    send_request(ACT_READ, '0, '0, '0, '1);
    send_request(ACT_FIND, dup_key, '0, '0, '0);
    send_request(ACT_FIND, dup_key ^ 64'd1, '0, '0, '0);
    send_request(ACT_ERASE, dup_key, '0, '0, '0);
    send_request(ACT_READ, '0, '0, '0, 6'd2);
    send_request(ACT_FIND, '1, '0, '0, '0);
    send_request(ACT_FIND, '0, '0, '0, '0);
    for (int c = ACT_CLEAR + 1; c <= ACT_CODE_MAX; c++)
      send_request(ACTION_W'(c), {$urandom(), $urandom()}, 4'($urandom()), $urandom(),
                   6'($urandom()));
    send_request(ACT_CLEAR, '0, '0, '0, '0);
    send_request(ACT_READ, '0, '0, '0, 6'd0);
  endtask

  // Fill the list to capacity with three interleaved keys, push past full,
  // read the top slot, erase one key out of the middle, refill and clear.
  task automatic test_full_list();
    logic [KEY_W-1:0] trio[3];
    foreach (trio[i]) trio[i] = {$urandom(), $urandom()};
    for (int i = 0; i < CAPACITY; i++)
      send_request(ACT_APPEND, trio[i % 3], 4'(i), $urandom(), 6'($urandom()));
    send_request(ACT_APPEND, trio[0], '1, '1, '0);
    send_request(ACT_APPEND, {$urandom(), $urandom()}, '0, '0, '0);
    send_request(ACT_READ, '0, '0, '0, 6'(CAPACITY - 1));
    send_request(ACT_READ, '0, '0, '0, 6'd0);
    send_request(ACT_FIND, trio[0], '0, '0, '0);
    send_request(ACT_ERASE, trio[1], '0, '0, '0);
    send_request(ACT_READ, '0, '0, '0, 6'(shadow_entries.size() - 1));
    send_request(ACT_READ, '0, '0, '0, 6'(shadow_entries.size()));
    send_request(ACT_ERASE, trio[1], '0, '0, '0);
    send_request(ACT_FIND, trio[1], '0, '0, '0);
    // Refill to capacity with fresh keys
    while (shadow_entries.size() < CAPACITY)
      send_request(ACT_APPEND, {$urandom(), $urandom()}, 4'($urandom()), $urandom(),
                   6'($urandom()));
    send_request(ACT_APPEND, trio[2], 4'($urandom()), $urandom(), '0);
    send_request(ACT_FIND, trio[2], '0, '0, '0);
    send_request(ACT_CLEAR, '0, '0, '0, '0);
    wait_for_results();
  endtask

  // Random mix weighted toward appends and lookups. Keys come mostly from a
  // small pool so find and erase hit often; the pool is renewed now and then.
  task automatic test_random_mix();
    int               pick;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
    refresh_key_pool();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 99) refresh_key_pool();
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1) wait_for_results();
      pick = $urandom_range(0, 99);
      key  = pick_key();
      // Read mostly in range, sometimes anywhere in the position field
      if ($urandom_range(0, 9) < 7 && shadow_entries.size() > 0)
        pos = POS_W'($urandom_range(0, shadow_entries.size() - 1));
      else
        pos = POS_W'($urandom());
      if (pick < 40)
        send_request(ACT_APPEND, key, 4'($urandom()), $urandom(), POS_W'($urandom()));
      else if (pick < 60)
        send_request(ACT_READ, key, 4'($urandom()), $urandom(), pos);
      else if (pick < 75)
        send_request(ACT_FIND, key, 4'($urandom()), $urandom(), pos);
      else if (pick < 95)
        send_request(ACT_ERASE, key, 4'($urandom()), $urandom(), pos);
      else if (pick < 97)
        send_request(ACT_CLEAR, key, 4'($urandom()), $urandom(), pos);
      else
        send_request(ACTION_W'($urandom_range(ACT_CLEAR + 1, ACT_CODE_MAX)), key,
                     4'($urandom()), $urandom(), pos);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_actions();
    test_full_list();
    test_random_mix();
    // Let every result come back, then watch for strays
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule
